// File: rtl/core/deq_pkg.sv
package deq_pkg;

  // Element width and ring depth; the word formats below are built from them.
  localparam int DATA_W = 32;
  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes carried in the func field.
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Status codes returned with every result.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         count;
    logic [1:0]               status;
  } out_word_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_LOAD
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // apply the accepted operation to pointers and store
    logic load;   // capture the read-back into the output register
  } ctrl_cmd_t;

endpackage

// File: rtl/core/deq_ram.sv
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: rtl/core/deq_ctrl.sv
module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::ctrl_cmd_t cmd
);

  deq_pkg::fsm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.exec  = 1'b0;
    cmd.load  = 1'b0;
    case (state_r)
      deq_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = deq_pkg::FSM_READ;
        end
      end
      deq_pkg::FSM_READ: begin
        state_nxt = deq_pkg::FSM_LOAD;
      end
      deq_pkg::FSM_LOAD: begin
        // Wait here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = deq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::FSM_IDLE;
      end
    endcase

    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == deq_pkg::FSM_READ)
    else $error("accepted word did not move on to the read cycle");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_stall_holds_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == deq_pkg::FSM_LOAD && out_valid_r && !out_ready)
      |=> state_r == deq_pkg::FSM_LOAD)
    else $error("result overwritten while output stalled");

endmodule

// File: rtl/core/deq_dpath.sv
module deq_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::ctrl_cmd_t cmd,
  input  deq_pkg::in_word_t  in_word,
  output deq_pkg::out_word_t out_word
);

  logic [deq_pkg::PTR_W-1:0] front_r, front_nxt;
  logic [deq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [1:0]                status_r, status_nxt;
  deq_pkg::out_word_t        out_word_r, out_word_nxt;

  logic                       full;
  logic                       empty;
  logic [deq_pkg::PTR_W-1:0]  front_inc;
  logic [deq_pkg::PTR_W-1:0]  front_dec;
  logic [deq_pkg::PTR_W-1:0]  tail_slot;
  logic [deq_pkg::PTR_W-1:0]  back_slot;
  logic [deq_pkg::CNT_W-1:0]  count_dec;

  logic                       ram_we;
  logic [deq_pkg::PTR_W-1:0]  ram_waddr;
  logic [deq_pkg::DATA_W-1:0] ram_wdata;
  logic [deq_pkg::DATA_W-1:0] ram_rdata_a;
  logic [deq_pkg::DATA_W-1:0] ram_rdata_b;

  // Modular add of two slot indexes, both below DEPTH.
  function automatic logic [deq_pkg::PTR_W-1:0] wrap_add(
    input logic [deq_pkg::PTR_W-1:0] a,
    input logic [deq_pkg::PTR_W-1:0] b
  );
    logic [deq_pkg::PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (deq_pkg::PTR_W + 1)'(deq_pkg::DEPTH)) begin
      sum = sum - (deq_pkg::PTR_W + 1)'(deq_pkg::DEPTH);
    end
    return sum[deq_pkg::PTR_W-1:0];
  endfunction

  assign full      = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - deq_pkg::CNT_W'(1);
  assign front_inc = (front_r == deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)) ?
                     '0 : front_r + deq_pkg::PTR_W'(1);
  assign front_dec = (front_r == '0) ?
                     deq_pkg::PTR_W'(deq_pkg::DEPTH - 1) : front_r - deq_pkg::PTR_W'(1);
  // The first free slot behind the back; only used when not full.
  assign tail_slot = wrap_add(front_r, count_r[deq_pkg::PTR_W-1:0]);
  // The back element; only meaningful when not empty.
  assign back_slot = wrap_add(front_r, count_dec[deq_pkg::PTR_W-1:0]);

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = tail_slot;
    ram_wdata  = in_word.data_in;
    if (cmd.exec) begin
      status_nxt = deq_pkg::STAT_OK;
      case (in_word.func)
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_dec;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_dec;
          end
        end
        deq_pkg::OP_CLEAR: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            front_nxt = '0;
            count_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_word_nxt        = out_word_r;
    if (cmd.load) begin
      out_word_nxt.count  = count_r;
      out_word_nxt.status = status_r;
      if (empty) begin
        out_word_nxt.front_value = '0;
        out_word_nxt.back_value  = '0;
      end else begin
        out_word_nxt.front_value = $signed(ram_rdata_a);
        out_word_nxt.back_value  = $signed(ram_rdata_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (front_r),
    .raddr_b (back_slot),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign out_word = out_word_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("element count beyond depth");

endmodule

// File: rtl/core/double_ended_queue.sv
// Channel   Direction  Ports                            Payload type
// input     in         in_valid, in_ready, in_word      deq_pkg::in_word_t
// result    out        out_valid, out_ready, out_word   deq_pkg::out_word_t
//
// Every operation word first updates the pointers and writes the ring store, then
// reads the front and back slots through the store's registered read port, and
// then loads the result register once the output register is free.
// Reset (rst_n low at a clock edge) empties the deque and sets the front to slot 0.
// A new word is taken while an earlier result still waits in the output register;
// a further result then holds in the controller until that register is taken.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_word_t out_word
);

  // The controller sequences each word through the update, read and load steps and owns the
  // output valid flag; the datapath holds the ring, its pointers and the result.
  deq_pkg::ctrl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The input word is sampled only in the cycle it is accepted, so the datapath
  // reads the port directly rather than through a holding register.
  deq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
